[src/twm_pkg.sv]
package twm_pkg;

	// Field widths of the stream words.
	localparam int TIME_W  = 31;
	localparam int LEN_W   = 24;
	localparam int ID_W    = 16;
	localparam int GAP_W   = 24;
	localparam int MARG_W  = 20;
	localparam int WIN_W   = 32;
	localparam int IN_DW   = 72;
	localparam int OUT_DW  = 64;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 24;

	// Result queue geometry.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [WIN_W-1:0] END_MAX = 32'h7FFF_FFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_AW-1:0] {
		REG_MATCH_A = 3'd0,
		REG_MATCH_B = 3'd1,
		REG_MATCH_C = 3'd2,
		REG_MATCH_D = 3'd3,
		REG_GAP     = 3'd4,
		REG_LEAD    = 3'd5,
		REG_TRAIL   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [ID_W-1:0]   match_a;
		logic [ID_W-1:0]   match_b;
		logic [ID_W-1:0]   match_c;
		logic [ID_W-1:0]   match_d;
		logic [GAP_W-1:0]  split_gap;
		logic [MARG_W-1:0] lead_margin;
		logic [MARG_W-1:0] trail_margin;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] trig_time;
		logic [LEN_W-1:0]  trig_length;
		logic              id_present;
		logic [ID_W-1:0]   trig_id;
		logic              frame_last;
	} trig_t;

	typedef struct packed {
		logic signed [WIN_W-1:0] win_start;
		logic signed [WIN_W-1:0] win_end;
		logic                    win_final;
	} window_t;

	typedef struct packed {
		logic    push0;
		logic    push1;
		window_t w0;
		window_t w1;
	} win_push_t;

	// Window end: running end plus trailing margin, saturated at the
	// largest positive 32-bit value.
	function automatic logic [WIN_W-1:0] sat_end(input logic [WIN_W-1:0] run_end,
			input logic [MARG_W-1:0] trail);
		logic [WIN_W:0] sum;
		begin
			sum = {1'b0, run_end} + {{(WIN_W + 1 - MARG_W){1'b0}}, trail};
			if (sum[WIN_W] || sum[WIN_W-1]) begin
				sat_end = END_MAX;
			end else begin
				sat_end = sum[WIN_W-1:0];
			end
		end
	endfunction

endpackage

[src/twm_core.sv]
module twm_core
	import twm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  trig_t     trig,
	input  cfg_t      cfg,
	output win_push_t res,
	output logic      window_open
);

	logic                    open_q;
	logic signed [WIN_W-1:0] start_q;
	logic [WIN_W-1:0]        run_end_q;

	logic                    used;
	logic [WIN_W-1:0]        t_ext;
	logic [WIN_W-1:0]        tend;
	logic [WIN_W:0]          limit;
	logic                    split;
	logic signed [WIN_W-1:0] new_start;
	logic                    open_nxt;
	logic signed [WIN_W-1:0] start_nxt;
	logic [WIN_W-1:0]        run_end_nxt;
	window_t                 split_win;
	window_t                 final_win;

	always_comb begin
		used = trig.id_present && (trig.trig_id == cfg.match_a ||
			trig.trig_id == cfg.match_b || trig.trig_id == cfg.match_c ||
			trig.trig_id == cfg.match_d);
		t_ext     = {{(WIN_W - TIME_W){1'b0}}, trig.trig_time};
		tend      = t_ext + {{(WIN_W - LEN_W){1'b0}}, trig.trig_length};
		// The running end never goes negative, so the gap test is unsigned.
		limit     = {1'b0, run_end_q} + {{(WIN_W + 1 - GAP_W){1'b0}}, cfg.split_gap};
		split     = used && open_q && ({1'b0, t_ext} > limit);
		new_start = $signed(t_ext - {{(WIN_W - MARG_W){1'b0}}, cfg.lead_margin});

		open_nxt    = open_q;
		start_nxt   = start_q;
		run_end_nxt = run_end_q;
		if (used) begin
			open_nxt = 1'b1;
			if (!open_q) begin
				start_nxt   = new_start;
				run_end_nxt = tend;
			end else begin
				if (split) begin
					start_nxt = new_start;
				end
				if (tend > run_end_q) begin
					run_end_nxt = tend;
				end
			end
		end

		split_win.win_start = start_q;
		split_win.win_end   = $signed(sat_end(run_end_q, cfg.trail_margin));
		split_win.win_final = 1'b0;
		final_win.win_start = start_nxt;
		final_win.win_end   = $signed(sat_end(run_end_nxt, cfg.trail_margin));
		final_win.win_final = 1'b1;

		res.push0 = fire && (split || (trig.frame_last && open_nxt));
		res.push1 = fire && split && trig.frame_last;
		res.w0    = split ? split_win : final_win;
		res.w1    = final_win;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			start_q   <= '0;
			run_end_q <= '0;
		end else if (fire) begin
			if (trig.frame_last) begin
				open_q    <= 1'b0;
				start_q   <= '0;
				run_end_q <= '0;
			end else begin
				open_q    <= open_nxt;
				start_q   <= start_nxt;
				run_end_q <= run_end_nxt;
			end
		end
	end

	assign window_open = open_q;

endmodule

[src/twm_outq.sv]
module twm_outq
	import twm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  win_push_t       res,
	output logic            room,
	output logic [Q_CW-1:0] count,
	output logic            out_valid,
	input  logic            out_ready,
	output window_t         out_win
);

	window_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_win   = mem_q[rd_ptr_q];
	assign room      = (count_q <= Q_CW'(Q_DEPTH - 2));
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (res.push0) begin
			mem_q[wr_ptr_q] <= res.w0;
		end
		if (res.push1) begin
			mem_q[wr_ptr_q + Q_AW'(1)] <= res.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(res.push0) + Q_AW'(res.push1);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			count_q  <= count_q + Q_CW'(res.push0) + Q_CW'(res.push1) - Q_CW'(pop);
		end
	end

endmodule

[src/trigger_window_merger_top.sv]
// Channel     | Direction | Ports                        | Word
// ------------+-----------+------------------------------+------------------------------------
// Trigger in  | in        | s_axis_tvalid/tready/tdata/  | tdata: trig_time, trig_length,
//             |           | tuser/tlast                  | trig_id; tuser: id_present;
//             |           |                              | tlast: frame_last
// Window out  | out       | m_axis_tvalid/tready/tdata/  | tdata: win_start, win_end;
//             |           | tlast                        | tlast: win_final
// Config      | in        | cfg_valid/ready/index/data   | register index and value
//
// A trigger word is taken into an input register and moves on to the window logic once
// the queue has room; at the end of that cycle its windows (none, one or two) are written
// into the output queue, whose head drives the output stream.
// One trigger word is accepted per cycle while the four-entry window queue has room for
// two more windows; a word that yields two windows writes both into the queue together.
// Reset clears the window state, the queue and restores the default register values.
// Configuration writes are always accepted and take effect on the next cycle.
module trigger_window_merger_top
	import twm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// Bits from the lowest up: trig_time[30:0], trig_length[54:31], trig_id[70:55], zero.
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// Bit 0: id_present.
	input  logic              s_axis_tuser,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// Bits from the lowest up: win_start[31:0], win_end[63:32].
	output logic [OUT_DW-1:0] m_axis_tdata,
	output logic              m_axis_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	// Configuration registers, always writable.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_a      <= 16'd1006;
			cfg_q.match_b      <= 16'd1007;
			cfg_q.match_c      <= 16'd1011;
			cfg_q.match_d      <= 16'd21001;
			cfg_q.split_gap    <= 24'd10000;
			cfg_q.lead_margin  <= 20'd4000;
			cfg_q.trail_margin <= 20'd6000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MATCH_A: cfg_q.match_a      <= cfg_data[ID_W-1:0];
				REG_MATCH_B: cfg_q.match_b      <= cfg_data[ID_W-1:0];
				REG_MATCH_C: cfg_q.match_c      <= cfg_data[ID_W-1:0];
				REG_MATCH_D: cfg_q.match_d      <= cfg_data[ID_W-1:0];
				REG_GAP:     cfg_q.split_gap    <= cfg_data[GAP_W-1:0];
				REG_LEAD:    cfg_q.lead_margin  <= cfg_data[MARG_W-1:0];
				REG_TRAIL:   cfg_q.trail_margin <= cfg_data[MARG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register. The held word moves on into the window logic only while the
	// queue can absorb two windows, so the result of any word always has a place.
	logic            s1_valid;
	trig_t           trig_s1;
	logic            room;
	logic            adv;
	logic [Q_CW-1:0] q_count;

	assign adv           = s1_valid && room;
	assign s_axis_tready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			trig_s1.trig_time   <= s_axis_tdata[TIME_W-1:0];
			trig_s1.trig_length <= s_axis_tdata[TIME_W+LEN_W-1:TIME_W];
			trig_s1.trig_id     <= s_axis_tdata[TIME_W+LEN_W+ID_W-1:TIME_W+LEN_W];
			trig_s1.id_present  <= s_axis_tuser;
			trig_s1.frame_last  <= s_axis_tlast;
		end
	end

	// Window tracking: match test, split decision, state update.
	win_push_t res;
	logic      window_open;

	twm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.trig        (trig_s1),
		.cfg         (cfg_q),
		.res         (res),
		.window_open (window_open)
	);

	// Result queue; its head register drives the output stream.
	window_t out_win;

	twm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.room      (room),
		.count     (q_count),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_win   (out_win)
	);

	assign m_axis_tdata = {out_win.win_end, out_win.win_start};
	assign m_axis_tlast = out_win.win_final;

	// The queue never holds more windows than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n) q_count <= Q_CW'(Q_DEPTH))
		else $error("window queue overflow");

	// A frame's last word always leaves the window state closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && trig_s1.frame_last |=> !window_open)
		else $error("window still open after frame end");

	// A held word that cannot move on stays in the input register unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !room |=> s1_valid && $stable(trig_s1))
		else $error("stalled trigger word lost or changed");

	// A second window in one cycle only comes with a first one.
	assert property (@(posedge clk) disable iff (!arst_n) res.push1 |-> res.push0)
		else $error("second window pushed without a first");

endmodule

[sim/trigger_window_merger_top_tb.sv]
module trigger_window_merger_top_tb;
	import twm_pkg::*;

	// Timing of the run. Inputs move on the falling edge and everything is
	// sampled on the rising edge, so nothing depends on event order.
	localparam int RESET_CYCLES = 11;
	// Cycles with nothing in flight before the block counts as idle.
	// A word passes the input register and the window queue on its way out, so this is ample.
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 12;
	localparam int SEG_WORDS = 205;
	localparam longint TIME_MAX = 64'h7FFF_FFFF;
	localparam longint WIN_MAX = 64'h7FFF_FFFF;
	// Index past the last register; a write there must change nothing.
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

	// Entries of the stimulus plan. Besides trigger words and register writes
	// the plan carries pacing changes, drain points and receiver hold-offs,
	// so the driver walks through the phases in order.
	typedef enum logic [2:0] {
		STEP_TRIG,
		STEP_CFG,
		STEP_DRAIN,
		STEP_PACE,
		STEP_HOLD
	} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		trig_t             trig;
		logic [CFG_AW-1:0] regsel;
		logic [CFG_DW-1:0] value;
		int                tx_idle;
		int                rx_stall;
	} stim_step_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_AW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	trigger_window_merger_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Plan and the generator's own view of the registers, used only to pick
	// trigger IDs and times that hit the interesting boundaries.
	stim_step_t plan[$];
	cfg_t       plan_cfg;

	// Window merger state as the testbench predicts it.
	cfg_t               cfg_m;
	logic               win_open;
	logic signed [31:0] open_start;
	logic [32:0]        run_end;
	window_t            windows_due[$];

	// Handshake bookkeeping. Each counter has exactly one writer.
	int   trig_offered = 0;
	int   trig_accepted = 0;
	int   cfg_offered = 0;
	int   cfg_accepted = 0;
	int   frames_closed = 0;
	int   windows_checked = 0;
	int   fails = 0;
	int   quiet = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   hold_seq = 0;
	logic stim_done = 1'b0;

	function automatic cfg_t reset_cfg();
		cfg_t c;
		c.match_a = 16'd1006;
		c.match_b = 16'd1007;
		c.match_c = 16'd1011;
		c.match_d = 16'd21001;
		c.split_gap = 24'd10000;
		c.lead_margin = 20'd4000;
		c.trail_margin = 20'd6000;
		return c;
	endfunction

	// Register write as the block sees it: values are cut to the register's
	// width, and an index without a register is dropped.
	function automatic cfg_t write_cfg(input cfg_t c, input logic [CFG_AW-1:0] idx,
			input logic [CFG_DW-1:0] val);
		case (idx)
		REG_MATCH_A: begin
			c.match_a = val[ID_W-1:0];
		end
		REG_MATCH_B: begin
			c.match_b = val[ID_W-1:0];
		end
		REG_MATCH_C: begin
			c.match_c = val[ID_W-1:0];
		end
		REG_MATCH_D: begin
			c.match_d = val[ID_W-1:0];
		end
		REG_GAP: begin
			c.split_gap = val[GAP_W-1:0];
		end
		REG_LEAD: begin
			c.lead_margin = val[MARG_W-1:0];
		end
		REG_TRAIL: begin
			c.trail_margin = val[MARG_W-1:0];
		end
		default: begin
		end
		endcase
		return c;
	endfunction

	function automatic logic id_selected(input cfg_t c, input logic present,
			input logic [ID_W-1:0] id);
		return present && (id == c.match_a || id == c.match_b ||
			id == c.match_c || id == c.match_d);
	endfunction

	// Queue one closed window. The end is the running end plus the trailing
	// margin, pinned at the largest positive 32-bit value.
	function automatic void emit_window(input logic fin);
		window_t w;
		longint e;
		e = longint'(run_end) + longint'(cfg_m.trail_margin);
		if (e > WIN_MAX) begin
			e = WIN_MAX;
		end
		w.win_start = open_start;
		w.win_end = 32'(e);
		w.win_final = fin;
		windows_due.insert(windows_due.size(), w);
	endfunction

	// Fold one accepted trigger word into the window state and queue the
	// windows it closes: a split emits the finished window, the frame's last
	// word emits whatever is still open and clears the state.
	function automatic void merge_trigger(input trig_t w);
		longint t;
		longint te;
		t = longint'(w.trig_time);
		te = t + longint'(w.trig_length);
		if (id_selected(cfg_m, w.id_present, w.trig_id)) begin
			if (!win_open) begin
				win_open = 1'b1;
				open_start = 32'(t - longint'(cfg_m.lead_margin));
				run_end = 33'(te);
			end else begin
				// Only a forward jump past the gap splits; a trigger that
				// is earlier than the running end at most extends it.
				if (t - longint'(run_end) > longint'(cfg_m.split_gap)) begin
					emit_window(1'b0);
					open_start = 32'(t - longint'(cfg_m.lead_margin));
				end
				if (te > longint'(run_end)) begin
					run_end = 33'(te);
				end
			end
		end
		if (w.frame_last) begin
			if (win_open) begin
				emit_window(1'b1);
			end
			win_open = 1'b0;
			open_start = '0;
			run_end = '0;
		end
	endfunction

	task automatic add_trig(input longint t, input longint len, input logic present,
			input logic [ID_W-1:0] id, input logic last);
		stim_step_t st;
		st.kind = STEP_TRIG;
		st.trig.trig_time = TIME_W'(t);
		st.trig.trig_length = LEN_W'(len);
		st.trig.id_present = present;
		st.trig.trig_id = id;
		st.trig.frame_last = last;
		plan.insert(plan.size(), st);
	endtask

	task automatic add_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		stim_step_t st;
		st.kind = STEP_CFG;
		st.regsel = idx;
		st.value = val;
		plan.insert(plan.size(), st);
		plan_cfg = write_cfg(plan_cfg, idx, val);
	endtask

	task automatic add_ctl(input step_kind_t kind, input int tx, input int rx);
		stim_step_t st;
		st.kind = kind;
		st.tx_idle = tx;
		st.rx_stall = rx;
		plan.insert(plan.size(), st);
	endtask

	function automatic logic [ID_W-1:0] pick_match();
		case ($urandom_range(3))
		0: begin
			return plan_cfg.match_a;
		end
		1: begin
			return plan_cfg.match_b;
		end
		2: begin
			return plan_cfg.match_c;
		end
		default: begin
			return plan_cfg.match_d;
		end
		endcase
	endfunction

	// One frame of random triggers. Times step forward a little from the last
	// trigger, or land at, just past, or well past the split gap beyond the end
	// of the used triggers so far; now and then one leaps ahead or goes back in time.
	task automatic gen_frame(input int n, inout int words);
		longint t;
		longint last_t;
		longint fend;
		longint len;
		longint gap;
		logic present;
		logic [ID_W-1:0] id;
		int r;
		gap = longint'(plan_cfg.split_gap);
		r = $urandom_range(9);
		if (r == 0) begin
			last_t = TIME_MAX - $urandom_range(200000);
		end else begin
			last_t = longint'($urandom & 32'h7FFF_FFFF);
		end
		fend = -1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(9);
			if (fend < 0 || r < 4) begin
				t = last_t + $urandom_range(2000);
			end else if (r == 4) begin
				t = fend + gap;
			end else if (r == 5) begin
				t = fend + gap + 1;
			end else if (r < 8) begin
				t = fend + gap + $urandom_range(2, 100000);
			end else if (r == 8) begin
				t = last_t + $urandom_range(1 << 20);
			end else begin
				t = last_t - $urandom_range(5000);
			end
			if (r >= 4 && r <= 7 && t < last_t) begin
				t = last_t;
			end
			if (t < 0) begin
				t = 0;
			end
			if (t > TIME_MAX) begin
				t = TIME_MAX;
			end
			if ($urandom_range(9) == 0) begin
				len = longint'($urandom & 32'h00FF_FFFF);
			end else begin
				len = $urandom_range(3000);
			end
			present = ($urandom_range(99) < 88);
			if ($urandom_range(99) < 75) begin
				id = pick_match();
			end else begin
				id = ID_W'($urandom);
			end
			add_trig(t, len, present, id, i == n - 1);
			if (id_selected(plan_cfg, present, id) && t + len > fend) begin
				fend = t + len;
			end
			last_t = t;
			words++;
		end
	endtask

	// Register settings for one segment: random, or gap and margins all at the low
	// end, or all at the high end. Upper data bits of the ID writes are random so that
	// masking to the register width is exercised.
	task automatic set_registers(input int flavor);
		logic [CFG_DW-1:0] gap;
		logic [CFG_DW-1:0] lead;
		logic [CFG_DW-1:0] trail;
		if (flavor == 1) begin
			add_cfg(REG_MATCH_A, 24'h000000);
			add_cfg(REG_MATCH_B, 24'hFFFFFF);
			add_cfg(REG_MATCH_C, 24'h5A0000);
			add_cfg(REG_MATCH_D, 24'h00FFFF);
			gap = '0;
			lead = '0;
			trail = '0;
		end else if (flavor == 2) begin
			add_cfg(REG_MATCH_A, 24'h00FFFF);
			add_cfg(REG_MATCH_B, 24'h000000);
			add_cfg(REG_MATCH_C, CFG_DW'($urandom));
			add_cfg(REG_MATCH_D, CFG_DW'($urandom));
			gap = 24'hFFFFFF;
			lead = 24'hFFFFFF;
			trail = 24'hFFFFFF;
		end else begin
			add_cfg(REG_MATCH_A, CFG_DW'($urandom));
			add_cfg(REG_MATCH_B, CFG_DW'($urandom));
			add_cfg(REG_MATCH_C, CFG_DW'($urandom));
			add_cfg(REG_MATCH_D, CFG_DW'($urandom));
			if ($urandom_range(3) == 0) begin
				gap = CFG_DW'($urandom);
			end else begin
				gap = $urandom_range(20000);
			end
			lead = CFG_DW'($urandom);
			trail = CFG_DW'($urandom);
		end
		add_cfg(REG_GAP, gap);
		add_cfg(REG_LEAD, lead);
		add_cfg(REG_TRAIL, trail);
	endtask

	// Driver. Walks the plan at most one entry per falling edge. A trigger word stays
	// on the bus until the monitor has counted its handshake; register writes
	// and drain points wait until the block has gone quiet.
	always @(negedge clk) begin : feed
		stim_step_t st;
		logic nv;
		logic ncv;
		logic idle;
		nv = (trig_offered != trig_accepted);
		ncv = (cfg_offered != cfg_accepted);
		idle = (windows_due.size() == 0) && (quiet >= SETTLE_CYCLES);
		if (arst_n && !nv && !ncv) begin
			if (plan.size() == 0) begin
				stim_done <= 1'b1;
			end else begin
				st = plan[0];
				case (st.kind)
				STEP_TRIG: begin
					if ($urandom_range(99) >= tx_idle_pct) begin
						s_axis_tdata <= {1'b0, st.trig.trig_id, st.trig.trig_length,
							st.trig.trig_time};
						s_axis_tuser <= st.trig.id_present;
						s_axis_tlast <= st.trig.frame_last;
						nv = 1'b1;
						trig_offered++;
						void'(plan.pop_front());
					end
				end
				STEP_CFG: begin
					if (idle) begin
						cfg_index <= st.regsel;
						cfg_data <= st.value;
						ncv = 1'b1;
						cfg_offered++;
						void'(plan.pop_front());
					end
				end
				STEP_DRAIN: begin
					if (idle) begin
						void'(plan.pop_front());
					end
				end
				STEP_PACE: begin
					tx_idle_pct = st.tx_idle;
					rx_stall_pct <= st.rx_stall;
					void'(plan.pop_front());
				end
				default: begin
					hold_seq <= hold_seq + 1;
					void'(plan.pop_front());
				end
				endcase
			end
		end
		s_axis_tvalid <= nv;
		cfg_valid <= ncv;
	end

	// Receiver. Stalls at the rate of the current phase; a hold-off request
	// from the driver makes it refuse every word for a long stretch, counted
	// here, while the driver keeps offering triggers.
	always @(negedge clk) begin : sink
		int hold_seen;
		int hold_left;
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Monitor. Checks each output word against the oldest predicted window,
	// then folds accepted trigger words and register writes into the model.
	always @(posedge clk) begin : watch
		window_t due;
		trig_t w;
		logic busy;
		busy = 1'b0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			busy = 1'b1;
			windows_checked++;
			if (windows_due.size() == 0) begin
				$error("unexpected window: win_start %0d, win_end %0d, win_final %0b",
					$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
					m_axis_tlast);
				fails++;
			end else begin
				due = windows_due.pop_front();
				if (m_axis_tdata[31:0] !== due.win_start) begin
					$error("win_start: expected %0d, got %0d", due.win_start,
						$signed(m_axis_tdata[31:0]));
					fails++;
				end
				if (m_axis_tdata[63:32] !== due.win_end) begin
					$error("win_end: expected %0d, got %0d", due.win_end,
						$signed(m_axis_tdata[63:32]));
					fails++;
				end
				if (m_axis_tlast !== due.win_final) begin
					$error("win_final: expected %0b, got %0b", due.win_final,
						m_axis_tlast);
					fails++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			busy = 1'b1;
			w.trig_time = s_axis_tdata[30:0];
			w.trig_length = s_axis_tdata[54:31];
			w.trig_id = s_axis_tdata[70:55];
			w.id_present = s_axis_tuser;
			w.frame_last = s_axis_tlast;
			merge_trigger(w);
			if (w.frame_last) begin
				frames_closed++;
			end
			trig_accepted++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			cfg_m = write_cfg(cfg_m, cfg_index, cfg_data);
			cfg_accepted++;
		end
		if (busy || windows_due.size() != 0) begin
			quiet = 0;
		end else if (quiet < 1000) begin
			quiet++;
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin : stimulus
		int words;
		int flavor;
		cfg_m = reset_cfg();
		plan_cfg = reset_cfg();
		win_open = 1'b0;
		open_start = '0;
		run_end = '0;

		// Directed part at the reset register values, full speed.
		add_ctl(STEP_PACE, 0, 0);
		// A single used trigger at time zero: the window starts below zero.
		add_trig(0, 0, 1'b1, 16'd1006, 1'b1);
		// Empty frames: an ID that is not marked present, and a foreign ID.
		add_trig(5000, 0, 1'b0, 16'd1006, 1'b1);
		add_trig(1000, 200, 1'b1, 16'd9, 1'b1);
		// Gap exactly at the threshold stays merged, one more splits, an
		// earlier trigger extends the end, and the closing word both splits
		// and ends the frame.
		add_trig(100000, 500, 1'b1, 16'd1007, 1'b0);
		add_trig(110500, 0, 1'b1, 16'd1011, 1'b0);
		add_trig(120501, 100, 1'b1, 16'd21001, 1'b0);
		add_trig(90000, 50000, 1'b1, 16'd1006, 1'b0);
		add_trig(150000, 0, 1'b0, 16'd1006, 1'b0);
		add_trig(150001, 7, 1'b1, 16'd1007, 1'b1);
		// An unused last word still closes the open window.
		add_trig(300000, 10, 1'b1, 16'd1006, 1'b0);
		add_trig(300020, 10, 1'b0, 16'd0, 1'b1);
		// Window end saturation at the top of the time range.
		add_trig(TIME_MAX, 24'hFFFFFF, 1'b1, 16'd1011, 1'b1);
		add_trig(TIME_MAX - 15, 0, 1'b1, 16'd1006, 1'b0);
		add_trig(TIME_MAX, 24'hFFFFFF, 1'b1, 16'd1007, 1'b1);
		// Extreme registers: zero gap, widest margins, IDs at both ends.
		add_cfg(REG_MATCH_A, 24'h000000);
		add_cfg(REG_MATCH_B, 24'hFFFFFF);
		add_cfg(REG_MATCH_C, 24'h000000);
		add_cfg(REG_MATCH_D, 24'h000000);
		add_cfg(REG_GAP, 24'h000000);
		add_cfg(REG_LEAD, 24'hFFFFFF);
		add_cfg(REG_TRAIL, 24'hFFFFFF);
		add_trig(0, 0, 1'b1, 16'h0000, 1'b0);
		add_trig(0, 5, 1'b1, 16'hFFFF, 1'b0);
		add_trig(6, 0, 1'b1, 16'h0000, 1'b0);
		add_trig(10, 0, 1'b0, 16'h0000, 1'b1);
		add_trig(TIME_MAX, 0, 1'b1, 16'hFFFF, 1'b1);

		// Random part: eight segments, two per pacing phase, each starting
		// from a drained block with fresh register settings.
		for (int seg = 0; seg < 8; seg++) begin
			add_ctl(STEP_DRAIN, 0, 0);
			flavor = (seg == 1) ? 1 : (seg == 5) ? 2 : 0;
			set_registers(flavor);
			if (seg == 3) begin
				add_cfg(REG_UNUSED, CFG_DW'($urandom));
			end
			case (seg / 2)
			0: begin
				add_ctl(STEP_PACE, 0, 0);
			end
			1: begin
				add_ctl(STEP_PACE, 77, 0);
			end
			2: begin
				add_ctl(STEP_PACE, 0, 77);
			end
			default: begin
				add_ctl(STEP_PACE, 21, 21);
			end
			endcase
			words = 0;
			while (words < SEG_WORDS) begin
				// Long receiver hold-off with the sender at full rate, so the
				// window queue fills and the input stalls.
				if (seg == 0 && words >= 90 && words < 100) begin
					add_ctl(STEP_HOLD, 0, 0);
					words = 100;
				end
				gen_frame($urandom_range(1, 10), words);
			end
		end

		// Reset is released on a falling edge, like every other input.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!stim_done || windows_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d trigger words in %0d frames and %0d register writes,",
			trig_accepted, frames_closed, cfg_accepted);
		$display("with %0d windows compared across four idle and stall phases.",
			windows_checked);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin : watchdog
		#1600000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
